>>> rtl/hcse_pkg.sv
// shared types, constants and commutation lookup for the hall speed estimator
package hcse_pkg;

  localparam int unsigned HALL_W   = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned COEF_W   = 17;
  localparam int unsigned WEIGHT_W = 11;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned RPM_W    = 17;
  localparam int unsigned PAIR_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned Q_SHIFT  = 10;
  localparam int unsigned PROD_W   = WEIGHT_W + RPM_W;
  localparam int unsigned ACC_W    = PROD_W - Q_SHIFT;
  localparam int unsigned SUM_W    = ACC_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [RPM_W-1:0]   RPM_MAX   = {RPM_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEFFICIENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_KEEP_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_NEW_WEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS        = 3'd4;

  // direction modes
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REV = 2'd2;

  // hall codes that no rotor position produces
  localparam logic [HALL_W-1:0] HALL_ALL_LOW  = 3'b000;
  localparam logic [HALL_W-1:0] HALL_ALL_HIGH = 3'b111;

  // drive pairs
  localparam logic [PAIR_W-1:0] PAIR_NONE = 3'd0;
  localparam logic [PAIR_W-1:0] PAIR_Q4Q1 = 3'd1;
  localparam logic [PAIR_W-1:0] PAIR_Q1Q6 = 3'd2;
  localparam logic [PAIR_W-1:0] PAIR_Q6Q3 = 3'd3;
  localparam logic [PAIR_W-1:0] PAIR_Q3Q2 = 3'd4;
  localparam logic [PAIR_W-1:0] PAIR_Q2Q5 = 3'd5;
  localparam logic [PAIR_W-1:0] PAIR_Q5Q4 = 3'd6;

  // reset values of the registers
  localparam logic [MODE_W-1:0]   RST_DIRECTION_MODE = MODE_FWD;
  localparam logic [COEF_W-1:0]   RST_SPEED_COEF     = 17'd30000;
  localparam logic [WEIGHT_W-1:0] RST_KEEP_WEIGHT    = 11'd669;
  localparam logic [WEIGHT_W-1:0] RST_NEW_WEIGHT     = 11'd355;
  localparam logic [COUNT_W-1:0]  RST_STALL_TICKS    = 16'd8000;

  // divider steps, one quotient bit each
  localparam int unsigned DIV_STEPS = RPM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL1,
    ST_MUL2,
    ST_DIVS,
    ST_DIV,
    ST_MUL3,
    ST_MUL4,
    ST_DONE
  } hcse_state_e;

  function automatic logic [PAIR_W-1:0] hcse_pick_pair(input logic [MODE_W-1:0] mode,
                                                        input logic [HALL_W-1:0] hall);
    logic [PAIR_W-1:0] fwd;
    logic [PAIR_W-1:0] rev;
    fwd = PAIR_NONE;
    rev = PAIR_NONE;
    case (hall)
      3'd1: begin
        fwd = PAIR_Q3Q2;
        rev = PAIR_Q4Q1;
      end
      3'd2: begin
        fwd = PAIR_Q5Q4;
        rev = PAIR_Q6Q3;
      end
      3'd3: begin
        fwd = PAIR_Q2Q5;
        rev = PAIR_Q1Q6;
      end
      3'd4: begin
        fwd = PAIR_Q1Q6;
        rev = PAIR_Q2Q5;
      end
      3'd5: begin
        fwd = PAIR_Q6Q3;
        rev = PAIR_Q5Q4;
      end
      3'd6: begin
        fwd = PAIR_Q4Q1;
        rev = PAIR_Q3Q2;
      end
      default: begin
        fwd = PAIR_NONE;
        rev = PAIR_NONE;
      end
    endcase
    if (mode == MODE_FWD) begin
      return fwd;
    end else if (mode == MODE_REV) begin
      return rev;
    end
    return PAIR_NONE;
  endfunction

endpackage

>>> rtl/hcse_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module hcse_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hcse_pkg::RPM_W-1:0]   dividend_i,
  input  logic [hcse_pkg::COUNT_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [hcse_pkg::RPM_W-1:0]   quotient_o
);
  import hcse_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [RPM_W-1:0]     quo_q, quo_d;
  logic [COUNT_W-1:0]   div_q, div_d;
  logic [COUNT_W:0]     shifted;
  logic [COUNT_W:0]     diff;
  logic                 fits;

  assign shifted = {rem_q, quo_q[RPM_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = (shifted >= {1'b0, div_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_d = {quo_q[RPM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/hall_commutation_speed_estimator.sv
// top level: hall commutation, tick filter, serial rpm divide and rpm filter
//
// one input word per pwm tick carries the three hall bits and the run flag and
// yields exactly one output word. a tick with no hall edge, or with run low,
// goes from the eval step straight to the done step, which loads the output
// register. a tick with a hall edge while running takes two passes through
// the shared 11x17 q10 multiplier for the tick-count filter, a bit-serial
// divide of the speed coefficient by the smoothed count (a start step, 17
// quotient steps and a finish step), and two more multiplier passes for the
// rpm filter. the input side stalls while a word is in work; a finished word
// sits in the output register, so the next input word can be accepted while
// the previous result is still stalled, and a word that finishes behind a
// stalled result waits in the last step until the slot frees. configuration
// writes go through a plain write port and are meant to happen while the
// block is idle.
module hall_commutation_speed_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [hcse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hcse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hcse_pkg::HALL_W-1:0]     hall_bits_i,
  input  logic                            run_enable_i,
  // output words
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hcse_pkg::PAIR_W-1:0]     drive_pair_o,
  output logic                            stop_drive_o,
  output logic                            stall_restart_o,
  output logic [hcse_pkg::RPM_W-1:0]      speed_rpm_o,
  output logic [hcse_pkg::RPM_W-1:0]      speed_rpm_smoothed_o
);
  import hcse_pkg::*;

  // configuration registers
  logic [MODE_W-1:0]   dir_mode_q;
  logic [COEF_W-1:0]   speed_coef_q;
  logic [WEIGHT_W-1:0] keep_w_q;
  logic [WEIGHT_W-1:0] new_w_q;
  logic [COUNT_W-1:0]  stall_ticks_q;

  // sequencer
  hcse_state_e state_q, state_d;

  // latched input word
  logic [HALL_W-1:0] hall_q;
  logic              run_q;

  // estimator state
  logic [HALL_W-1:0]  prev_hall_q;
  logic [COUNT_W-1:0] tick_q;
  logic [COUNT_W-1:0] sc_q;
  logic [RPM_W-1:0]   rpm_q;
  logic [RPM_W-1:0]   rs_q;

  // result of the word in work
  logic [PAIR_W-1:0] pair_q;
  logic              stop_q;
  logic              stall_q;

  // shared multiply-accumulate
  logic [ACC_W-1:0]    acc_q;
  logic [WEIGHT_W-1:0] mul_a;
  logic [RPM_W-1:0]    mul_b;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    prod_q10;
  logic [SUM_W-1:0]    sum;

  // control strobes
  logic in_take;
  logic div_start;
  logic div_done;
  logic out_load;
  logic [RPM_W-1:0]   div_quo;
  logic [COUNT_W-1:0] divisor;

  // combinational decisions for the eval step
  logic              hall_ok;
  logic              hall_edge;
  logic [COUNT_W-1:0] tick_inc;
  logic              stall_hit;
  logic [PAIR_W-1:0]  pair_pick;

  // output register
  logic out_valid_q;

  assign hall_ok   = (hall_q != HALL_ALL_LOW) && (hall_q != HALL_ALL_HIGH);
  assign hall_edge = (hall_q != prev_hall_q);
  assign tick_inc  = (tick_q == COUNT_MAX) ? tick_q : tick_q + 1'b1;
  assign stall_hit = (tick_inc >= stall_ticks_q);
  assign pair_pick = hcse_pick_pair(dir_mode_q, hall_q);

  // a zero smoothed count divides as one
  assign divisor = (sc_q == '0) ? COUNT_W'(1) : sc_q;

  // q10 product, truncated before it joins the accumulator
  assign prod     = mul_a * mul_b;
  assign prod_q10 = prod[PROD_W-1:Q_SHIFT];
  assign sum      = {1'b0, acc_q} + {1'b0, prod_q10};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = (run_q && hall_edge) ? ST_MUL1 : ST_DONE;
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_DIVS;
      ST_DIVS: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL3;
        end
      end
      ST_MUL3: state_d = ST_MUL4;
      ST_MUL4: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_take    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE: in_take = in_valid_i;
      ST_MUL1: begin
        mul_a = keep_w_q;
        mul_b = RPM_W'(sc_q);
      end
      ST_MUL2: begin
        mul_a = new_w_q;
        mul_b = RPM_W'(tick_q);
      end
      ST_DIVS: div_start = 1'b1;
      ST_MUL3: begin
        mul_a = keep_w_q;
        mul_b = rs_q;
      end
      ST_MUL4: begin
        mul_a = new_w_q;
        mul_b = rpm_q;
      end
      ST_DONE: out_load = !out_valid_q || !out_stall_i;
      default: begin
        in_take = 1'b0;
      end
    endcase
  end

  hcse_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (speed_coef_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // control, configuration and estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dir_mode_q    <= RST_DIRECTION_MODE;
      speed_coef_q  <= RST_SPEED_COEF;
      keep_w_q      <= RST_KEEP_WEIGHT;
      new_w_q       <= RST_NEW_WEIGHT;
      stall_ticks_q <= RST_STALL_TICKS;
      prev_hall_q   <= '0;
      tick_q        <= '0;
      sc_q          <= '0;
      rpm_q         <= '0;
      rs_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DIRECTION_MODE:     dir_mode_q    <= cfg_wdata_i[MODE_W-1:0];
          CFG_SPEED_COEFFICIENT:  speed_coef_q  <= cfg_wdata_i[COEF_W-1:0];
          CFG_FILTER_KEEP_WEIGHT: keep_w_q      <= cfg_wdata_i[WEIGHT_W-1:0];
          CFG_FILTER_NEW_WEIGHT:  new_w_q       <= cfg_wdata_i[WEIGHT_W-1:0];
          CFG_STALL_TICKS:        stall_ticks_q <= cfg_wdata_i[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_q)
        ST_EVAL: begin
          prev_hall_q <= hall_q;
          // no edge while running: count the tick and check for a stall
          if (run_q && !hall_edge) begin
            if (stall_hit) begin
              tick_q <= '0;
              rs_q   <= '0;
              if (!hall_ok) begin
                rpm_q <= '0;
              end
            end else begin
              tick_q <= tick_inc;
            end
          end
        end
        ST_MUL2: begin
          // smoothed tick count, saturated to its width
          sc_q   <= (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
          tick_q <= '0;
        end
        ST_DIV: begin
          if (div_done) begin
            rpm_q <= div_quo;
          end
        end
        ST_MUL4: begin
          rs_q <= (sum > SUM_W'(RPM_MAX)) ? RPM_MAX : sum[RPM_W-1:0];
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      hall_q <= hall_bits_i;
      run_q  <= run_enable_i;
    end

    case (state_q)
      ST_EVAL: begin
        if (run_q && hall_edge) begin
          // invalid hall code on an edge stops the drive
          pair_q  <= hall_ok ? pair_pick : PAIR_NONE;
          stop_q  <= !hall_ok;
          stall_q <= 1'b0;
        end else if (run_q && stall_hit) begin
          // stall restart re-applies the current pair, none for an invalid hall code
          pair_q  <= hall_ok ? pair_pick : PAIR_NONE;
          stop_q  <= 1'b1;
          stall_q <= 1'b1;
        end else begin
          pair_q  <= PAIR_NONE;
          stop_q  <= 1'b0;
          stall_q <= 1'b0;
        end
      end
      ST_MUL1: acc_q <= prod_q10;
      ST_MUL3: acc_q <= prod_q10;
      default: begin
      end
    endcase

    if (out_load) begin
      drive_pair_o         <= pair_q;
      stop_drive_o         <= stop_q;
      stall_restart_o      <= stall_q;
      speed_rpm_o          <= rpm_q;
      speed_rpm_smoothed_o <= rs_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // a stall restart always stops the drive and clears the filtered speed
  a_stall_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stall_restart_o |-> stop_drive_o && (speed_rpm_smoothed_o == '0))
    else $error("stall restart without stop or with nonzero smoothed rpm");

  // a stop on an edge means an invalid hall code, so no pair is driven
  a_edge_stop_no_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_drive_o && !stall_restart_o |-> drive_pair_o == PAIR_NONE)
    else $error("pair driven on an edge stop");

  // the divider only reports back while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  // a word is only taken into the output register when the slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || !out_stall_i)
    else $error("output word overwritten while stalled");

  // every accepted input word leads to the eval step
  a_take_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_EVAL)
    else $error("accepted word not evaluated");
`endif

endmodule

>>> test/tb.sv
// self-checking testbench for the hall commutation speed estimator
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcse_pkg::*;

  // direction mode code that selects no table, not named in the package
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // hall order of one forward electrical turn in the first table
  localparam logic [HALL_W-1:0] ROTATION [6] = '{3'd6, 3'd4, 3'd5, 3'd1, 3'd3, 3'd2};

  // cycles with no accepted word before the run is called hung
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 85;

  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic              stop;
    logic              restart;
    logic [RPM_W-1:0]  rpm;
    logic [RPM_W-1:0]  rpm_avg;
  } drive_word_t;

  // tracks commutation and speed state, holds the drive words still owed
  class drive_tracker;
    logic [MODE_W-1:0]   dir_mode;
    logic [COEF_W-1:0]   coef;
    logic [WEIGHT_W-1:0] keep_w;
    logic [WEIGHT_W-1:0] new_w;
    logic [COUNT_W-1:0]  stall_limit;

    logic [HALL_W-1:0]   last_hall;
    logic [COUNT_W-1:0]  ticks;
    logic [COUNT_W-1:0]  count_avg;
    logic [RPM_W-1:0]    rpm_now;
    logic [RPM_W-1:0]    rpm_avg;

    logic [PAIR_W-1:0]   fwd_pair [8];
    logic [PAIR_W-1:0]   rev_pair [8];

    drive_word_t         expected_words [$];
    int unsigned         failures;
    int unsigned         checked;

    function new();
      dir_mode    = RST_DIRECTION_MODE;
      coef        = RST_SPEED_COEF;
      keep_w      = RST_KEEP_WEIGHT;
      new_w       = RST_NEW_WEIGHT;
      stall_limit = RST_STALL_TICKS;
      last_hall   = '0;
      ticks       = '0;
      count_avg   = '0;
      rpm_now     = '0;
      rpm_avg     = '0;
      failures    = 0;
      checked     = 0;
      fwd_pair = '{PAIR_NONE, PAIR_Q3Q2, PAIR_Q5Q4, PAIR_Q2Q5,
                   PAIR_Q1Q6, PAIR_Q6Q3, PAIR_Q4Q1, PAIR_NONE};
      rev_pair = '{PAIR_NONE, PAIR_Q4Q1, PAIR_Q6Q3, PAIR_Q1Q6,
                   PAIR_Q2Q5, PAIR_Q5Q4, PAIR_Q3Q2, PAIR_NONE};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DIRECTION_MODE:     dir_mode    = val[MODE_W-1:0];
        CFG_SPEED_COEFFICIENT:  coef        = val[COEF_W-1:0];
        CFG_FILTER_KEEP_WEIGHT: keep_w      = val[WEIGHT_W-1:0];
        CFG_FILTER_NEW_WEIGHT:  new_w       = val[WEIGHT_W-1:0];
        CFG_STALL_TICKS:        stall_limit = val[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PAIR_W-1:0] pair_for(logic [HALL_W-1:0] hall);
      case (dir_mode)
        MODE_FWD: return fwd_pair[hall];
        MODE_REV: return rev_pair[hall];
        default:  return PAIR_NONE;
      endcase
    endfunction

    // q10 first-order filter, each product truncated, sum clipped at cap
    function logic [31:0] blend(logic [31:0] prev, logic [31:0] sample, logic [31:0] cap);
      logic [31:0] kept;
      logic [31:0] fresh;
      logic [31:0] sum;
      kept  = (keep_w * prev) >> Q_SHIFT;
      fresh = (new_w * sample) >> Q_SHIFT;
      sum   = kept + fresh;
      return (sum > cap) ? cap : sum;
    endfunction

    // one accepted tick word in, one expected drive word queued
    function void note_tick(logic [HALL_W-1:0] hall, logic run);
      drive_word_t w;
      logic        hall_ok;
      w = '0;
      hall_ok = (hall != HALL_ALL_LOW) && (hall != HALL_ALL_HIGH);
      if (run) begin
        if (hall != last_hall) begin
          if (hall_ok) begin
            w.pair = pair_for(hall);
          end else begin
            w.stop = 1'b1;
          end
          count_avg = COUNT_W'(blend(32'(count_avg), 32'(ticks), 32'(COUNT_MAX)));
          rpm_now   = coef / ((count_avg == '0) ? COUNT_W'(1) : count_avg);
          rpm_avg   = RPM_W'(blend(32'(rpm_avg), 32'(rpm_now), 32'(RPM_MAX)));
          ticks     = '0;
        end else begin
          if (ticks != COUNT_MAX) ticks++;
          if (ticks >= stall_limit) begin
            ticks     = '0;
            rpm_avg   = '0;
            w.stop    = 1'b1;
            w.restart = 1'b1;
            if (hall_ok) begin
              w.pair = pair_for(hall);
            end else begin
              rpm_now = '0;
            end
          end
        end
      end
      last_hall = hall;
      w.rpm     = rpm_now;
      w.rpm_avg = rpm_avg;
      expected_words.push_back(w);
    endfunction

    function void check_drive_word(drive_word_t got);
      drive_word_t want;
      checked++;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("drive word %0d arrived with none owed:", checked);
          $display("  pair %0d stop %0d restart %0d rpm %0d avg %0d",
                   got.pair, got.stop, got.restart, got.rpm, got.rpm_avg);
        end
        return;
      end
      want = expected_words.pop_front();
      if (got.pair !== want.pair || got.stop !== want.stop || got.restart !== want.restart ||
          got.rpm !== want.rpm || got.rpm_avg !== want.rpm_avg) begin
        failures++;
        if (failures <= 10) begin
          $display("drive word %0d mismatch:", checked);
          $display("  want pair %0d stop %0d restart %0d rpm %0d avg %0d",
                   want.pair, want.stop, want.restart, want.rpm, want.rpm_avg);
          $display("  got  pair %0d stop %0d restart %0d rpm %0d avg %0d",
                   got.pair, got.stop, got.restart, got.rpm, got.rpm_avg);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [HALL_W-1:0]     hall_bits_i;
  logic                  run_enable_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PAIR_W-1:0]     drive_pair_o;
  logic                  stop_drive_o;
  logic                  stall_restart_o;
  logic [RPM_W-1:0]      speed_rpm_o;
  logic [RPM_W-1:0]      speed_rpm_smoothed_o;

  drive_tracker tracker;
  drive_word_t  seen_word;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  quiet_cycles;

  hall_commutation_speed_estimator DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .hall_bits_i          (hall_bits_i),
    .run_enable_i         (run_enable_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .drive_pair_o         (drive_pair_o),
    .stop_drive_o         (stop_drive_o),
    .stall_restart_o      (stall_restart_o),
    .speed_rpm_o          (speed_rpm_o),
    .speed_rpm_smoothed_o (speed_rpm_smoothed_o)
  );

  always #5 clk_i = ~clk_i;

  // output side: outputs are sampled at the edge before any update lands,
  // then the stall for the next cycle is drawn
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      seen_word.pair    = drive_pair_o;
      seen_word.stop    = stop_drive_o;
      seen_word.restart = stall_restart_o;
      seen_word.rpm     = speed_rpm_o;
      seen_word.rpm_avg = speed_rpm_smoothed_o;
      tracker.check_drive_word(seen_word);
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // hang detector: any accepted word on either side restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one tick word: random gap first, then hold valid until taken
  task send_word(input logic [HALL_W-1:0] hall, input logic run);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hall_bits_i  <= hall;
    run_enable_i <= run;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_tick(hall, run);
  endtask

  // drop valid and wait until every owed drive word is back
  task drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    tracker.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // back-to-back writes of all five registers, only while the block is idle
  task apply_settings(input logic [MODE_W-1:0] mode, input logic [COEF_W-1:0] coef,
                      input logic [WEIGHT_W-1:0] keep_w, input logic [WEIGHT_W-1:0] new_w,
                      input logic [COUNT_W-1:0] stall);
    write_reg(CFG_DIRECTION_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_SPEED_COEFFICIENT, CFG_DATA_W'(coef));
    write_reg(CFG_FILTER_KEEP_WEIGHT, CFG_DATA_W'(keep_w));
    write_reg(CFG_FILTER_NEW_WEIGHT, CFG_DATA_W'(new_w));
    write_reg(CFG_STALL_TICKS, CFG_DATA_W'(stall));
    cfg_we_i <= 1'b0;
  endtask

  // mostly a turning rotor: walk the hall ring, dwell a random number of
  // ticks per state so some dwells run into a short stall limit, now and then
  // turn round; the rest is glitches and ticks with run low
  task run_random_phase(input int unsigned target);
    int unsigned       counted;
    int unsigned       hold;
    int unsigned       hold_max;
    int unsigned       pos;
    int unsigned       pick;
    logic [HALL_W-1:0] hall;
    logic              run;
    logic              backward;
    counted  = 0;
    pos      = $urandom_range(0, 5);
    backward = 1'($urandom_range(0, 1));
    hold_max = (tracker.stall_limit < 14) ? tracker.stall_limit + 3 : 16;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // glitch: any hall code, invalid ones included
        hall = HALL_W'($urandom_range(0, 7));
        run  = 1'($urandom_range(0, 1));
        send_word(hall, run);
        if (run) counted++;
      end else if (pick < 15) begin
        // drive off, only the hall state is tracked
        send_word(ROTATION[pos], 1'b0);
      end else begin
        if ($urandom_range(0, 19) == 0) backward = !backward;
        pos  = backward ? (pos + 5) % 6 : (pos + 1) % 6;
        hold = $urandom_range(1, hold_max);
        repeat (hold) begin
          send_word(ROTATION[pos], 1'b1);
          counted++;
        end
      end
    end
  endtask

  initial begin
    tracker        = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    hall_bits_i    = '0;
    run_enable_i   = 1'b0;
    out_stall_i    = 1'b0;
    quiet_cycles   = 0;
    send_idle_pct  = 29;
    recv_stall_pct = 84;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: drive off, a still rotor, one forward turn, then both
    // invalid hall codes arriving as edges
    send_word(HALL_ALL_HIGH, 1'b0);
    send_word(HALL_ALL_HIGH, 1'b1);
    send_word(3'd6, 1'b1);
    send_word(3'd6, 1'b1);
    for (int i = 1; i < 6; i++) send_word(ROTATION[i], 1'b1);
    send_word(HALL_ALL_LOW, 1'b1);
    send_word(HALL_ALL_HIGH, 1'b1);
    send_word(3'd5, 1'b0);
    drain();

    // reverse table, widest coefficient and weights so the rpm filter clips,
    // short stall limit hit on a valid and then an invalid hall state
    apply_settings(MODE_REV, COEF_W'(131071), WEIGHT_W'(2047), WEIGHT_W'(2047), COUNT_W'(2));
    send_word(3'd6, 1'b1);
    send_word(3'd6, 1'b1);
    send_word(3'd6, 1'b1);
    for (int i = 1; i < 6; i++) send_word(ROTATION[i], 1'b1);
    send_word(HALL_ALL_HIGH, 1'b1);
    send_word(HALL_ALL_HIGH, 1'b1);
    send_word(HALL_ALL_HIGH, 1'b1);
    drain();

    // unused mode, zero coefficient, zero stall limit fires on every still tick
    apply_settings(MODE_UNUSED, '0, '0, WEIGHT_W'(1024), '0);
    send_word(HALL_ALL_HIGH, 1'b1);
    send_word(3'd1, 1'b1);
    send_word(3'd1, 1'b1);
    drain();

    // random part, sender light and receiver heavy
    apply_settings(MODE_FWD, COEF_W'(30000), WEIGHT_W'(669), WEIGHT_W'(355), COUNT_W'(12));
    run_random_phase(RANDOM_WORDS);
    drain();
    apply_settings(MODE_REV, COEF_W'($urandom_range(1, 131071)),
                   WEIGHT_W'($urandom_range(0, 1024)), WEIGHT_W'($urandom_range(0, 1024)),
                   COUNT_W'($urandom_range(1, 20)));
    run_random_phase(RANDOM_WORDS);
    drain();

    // sender heavy, receiver light
    send_idle_pct  = 84;
    recv_stall_pct = 29;
    apply_settings(MODE_OFF, COEF_W'(131071), WEIGHT_W'(2047), WEIGHT_W'(2047),
                   COUNT_W'(65535));
    run_random_phase(RANDOM_WORDS);
    drain();
    apply_settings(MODE_UNUSED, COEF_W'(1), '0, '0, COUNT_W'(1));
    run_random_phase(RANDOM_WORDS);
    drain();

    // no idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_settings(MODE_FWD, COEF_W'($urandom_range(0, 131071)),
                   WEIGHT_W'($urandom_range(0, 2047)), WEIGHT_W'($urandom_range(0, 2047)),
                   COUNT_W'($urandom_range(0, 16)));
    run_random_phase(RANDOM_WORDS);
    drain();
    apply_settings(MODE_REV, COEF_W'(120000), WEIGHT_W'(1024), '0, COUNT_W'(5));
    run_random_phase(RANDOM_WORDS);
    drain();

    // room for a late or extra word to show up
    repeat (40) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
